>>> src/wmm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the window minimizer marker
// no dependencies; imported by every module of the block

package wmm_pkg;

  // field widths fixed by the stream format
  localparam int unsigned HASH_W = 64;
  localparam int unsigned CFG_W  = 6;

  // hash value that stands for a position without a k-mer
  localparam logic [HASH_W-1:0] NO_KMER = '1;

  // window size after reset
  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd8;

  // control from the sequencer to the minimum unit
  typedef struct packed {
    logic start;  // clear the running minimum before a scan
    logic cmp;    // read data holds a window entry to compare
  } wmm_min_ctrl_t;

endpackage

>>> src/wmm_value_ram.sv
`timescale 1ns / 1ps
// hash value store of the window buffer: one write port, one registered read port
// depends on wmm_pkg for the hash width

module wmm_value_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [wmm_pkg::HASH_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [wmm_pkg::HASH_W-1:0] rd_data
);
  import wmm_pkg::*;

  logic [HASH_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its data while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/wmm_min_unit.sv
`timescale 1ns / 1ps
// shared comparator that tracks the leftmost strict minimum of a window scan
// depends on wmm_pkg for the hash width and the control struct

module wmm_min_unit #(
  parameter int unsigned AW = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wmm_pkg::wmm_min_ctrl_t     ctrl,
  input  logic [wmm_pkg::HASH_W-1:0] data,
  input  logic [AW-1:0]              ptr,
  output logic [wmm_pkg::HASH_W-1:0] min_val,
  output logic [AW-1:0]              min_ptr
);
  import wmm_pkg::*;

  logic have_min;

  // first entry always taken, later ones only when strictly smaller
  always_ff @(posedge clk) begin
    if (rst) begin
      have_min <= 1'b0;
    end else if (ctrl.start) begin
      have_min <= 1'b0;
    end else if (ctrl.cmp) begin
      have_min <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp && (!have_min || data < min_val)) begin
      min_val <= data;
      min_ptr <= ptr;
    end
  end

endmodule

>>> src/window_minimizer_marker.sv
`timescale 1ns / 1ps
// top level of the window minimizer marker: sequencer, mark flags and output register
// depends on wmm_pkg, wmm_value_ram and wmm_min_unit

// Usage
// - s_axis carries one request per sequence position: the 64-bit k-mer hash in
//   tdata, tlast on the final position. A hash of all ones means no k-mer.
// - m_axis returns each position once it is final, in input order: hash in tdata,
//   the minimizer mark in tuser, tlast on the final position of the sequence.
// - cfg carries the window size (0 acts as 1, sizes above MAX_WINDOW saturate);
//   write it only while the block is idle.
// - s_axis_tready is high only while the sequencer waits for input. A request
//   that completes a window of W positions takes insert, check, a scan (one
//   comparator scans one buffered entry per cycle), read and output steps; one
//   that leaves the window not full takes only insert and check. On tlast each
//   remaining buffered position is flushed through check, read and output.
// - a result sits in the output register until taken; while the receiver
//   stalls the sequencer waits before popping the next position.
// - reset empties the buffer, clears all marks and sets the window size to 8.
//   No clearing pass is needed.

module window_minimizer_marker #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [wmm_pkg::HASH_W-1:0] s_axis_tdata,   // [63:0] hash_value
  input  logic                       s_axis_tlast,   // end_of_sequence
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [wmm_pkg::HASH_W-1:0] m_axis_tdata,   // [63:0] position_value
  output logic                       m_axis_tuser,   // [0] is_minimizer
  output logic                       m_axis_tlast,   // last_of_sequence
  // window size write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wmm_pkg::CFG_W-1:0]  cfg_data
);
  import wmm_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_WINDOW);
  localparam logic [CFG_W:0] MAX_CFG = (CFG_W + 1)'(MAX_WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_POP_RD,
    ST_POP_OUT
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  window_size;
  logic [CW-1:0]     win_eff;
  logic [CW-1:0]     fill;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic              eos;
  logic              marks [MAX_WINDOW];
  logic [AW-1:0]     issue_ptr;
  logic [CW-1:0]     issue_cnt;
  logic              cmp_valid;
  logic [AW-1:0]     cmp_ptr;
  logic              out_valid;
  logic              out_load;
  logic [HASH_W-1:0] out_data;
  logic              out_mark;
  logic              out_last;

  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [HASH_W-1:0] rd_data;
  wmm_min_ctrl_t     min_ctrl;
  logic [HASH_W-1:0] min_val;
  logic [AW-1:0]     min_ptr;

  // circular buffer pointer step
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  // effective window length
  always_comb begin
    if (window_size == '0) begin
      win_eff = CW'(1);
    end else if ({1'b0, window_size} > MAX_CFG) begin
      win_eff = MAX_CNT;
    end else begin
      win_eff = CW'(window_size);
    end
  end

  // handshakes and memory control
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign wr_en         = s_axis_tvalid && s_axis_tready;
  assign rd_en         = ((state == ST_SCAN) && (issue_cnt != win_eff)) ||
                         (state == ST_POP_RD);
  assign rd_addr       = (state == ST_SCAN) ? issue_ptr : head;
  assign out_load      = (state == ST_POP_OUT) && (!out_valid || m_axis_tready);

  assign min_ctrl.start = (state == ST_CHECK) && (fill >= win_eff);
  assign min_ctrl.cmp   = (state == ST_SCAN) && cmp_valid;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_mark;
  assign m_axis_tlast  = out_last;

  wmm_value_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (s_axis_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wmm_min_unit #(
    .AW (AW)
  ) u_min_unit (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (min_ctrl),
    .data    (rd_data),
    .ptr     (cmp_ptr),
    .min_val (min_val),
    .min_ptr (min_ptr)
  );

  // sequencer: insert, scan full windows, pop finished positions, flush on tlast
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      window_size <= WINDOW_RESET;
      fill        <= '0;
      head        <= '0;
      tail        <= '0;
      eos         <= 1'b0;
      issue_ptr   <= '0;
      issue_cnt   <= '0;
      cmp_valid   <= 1'b0;
      cmp_ptr     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        marks[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
      // output register: loaded by the pop step, cleared once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (wr_en) begin
            marks[tail] <= 1'b0;
            tail        <= ptr_inc(tail);
            fill        <= fill + CW'(1);
            eos         <= s_axis_tlast;
            state       <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (fill >= win_eff) begin
            issue_ptr <= head;
            issue_cnt <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SCAN;
          end else if (eos && fill != '0) begin
            state <= ST_POP_RD;
          end else begin
            eos   <= 1'b0;
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (issue_cnt != win_eff) begin
            issue_ptr <= ptr_inc(issue_ptr);
            issue_cnt <= issue_cnt + CW'(1);
            cmp_valid <= 1'b1;
            cmp_ptr   <= issue_ptr;
          end else begin
            cmp_valid <= 1'b0;
            // last compare has landed: mark the minimum unless it is the sentinel
            if (!cmp_valid) begin
              if (min_val != NO_KMER) begin
                marks[min_ptr] <= 1'b1;
              end
              state <= ST_POP_RD;
            end
          end
        end
        ST_POP_RD: begin
          state <= ST_POP_OUT;
        end
        ST_POP_OUT: begin
          if (out_load) begin
            marks[head] <= 1'b0;
            head        <= ptr_inc(head);
            fill        <= fill - CW'(1);
            state       <= ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= rd_data;
      out_mark <= marks[head];
      out_last <= eos && (fill == CW'(1));
    end
  end

  // buffer never holds more than the store depth
  assert property (@(posedge clk) disable iff (rst) fill <= MAX_CNT)
    else $error("window buffer overfilled");

  // a new position only arrives while the buffer has room
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> (fill < MAX_CNT))
    else $error("input taken while the buffer is full");

  // an empty buffer has matching pointers
  assert property (@(posedge clk) disable iff (rst) (fill == '0) |-> (head == tail))
    else $error("head and tail disagree on an empty buffer");

  // the final result of a sequence leaves the buffer empty
  assert property (@(posedge clk) disable iff (rst)
    (out_load && eos && fill == CW'(1)) |=> (fill == '0))
    else $error("buffer not empty after the final result");

  // scans only start from the check step with a full window
  assert property (@(posedge clk) disable iff (rst)
    ($rose(state == ST_SCAN)) |-> ($past(state) == ST_CHECK && issue_cnt == '0))
    else $error("scan entered out of sequence");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for window_minimizer_marker: streams hash runs, predicts marks
// depends on wmm_pkg and the window_minimizer_marker rtl

module tb_top;
  import wmm_pkg::*;

  localparam int unsigned MAX_WIN = 32;

  // one finalized position as it leaves the block
  typedef struct packed {
    logic [HASH_W-1:0] value;
    logic              mark;
    logic              last;
  } final_pos_t;

  // window model plus queue of positions still owed by the block
  class minimizer_scoreboard;
    logic [HASH_W-1:0] held_hash [MAX_WIN];
    bit                held_mark [MAX_WIN];
    int unsigned       held_count;
    logic [CFG_W-1:0]  win_reg;
    final_pos_t        owed_q [$];
    int unsigned       errors;

    function new();
      win_reg    = WINDOW_RESET;
      held_count = 0;
      errors     = 0;
      for (int i = 0; i < MAX_WIN; i++) begin
        held_hash[i] = '0;
        held_mark[i] = 1'b0;
      end
    endfunction

    function void write_window(logic [CFG_W-1:0] w);
      win_reg = w;
    endfunction

    // zero acts as one, oversize saturates
    function int unsigned span();
      if (win_reg == 0) return 1;
      if (win_reg > MAX_WIN) return MAX_WIN;
      return win_reg;
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    // oldest buffered position becomes final
    function void retire_oldest(bit last);
      final_pos_t r;
      r.value = held_hash[0];
      r.mark  = held_mark[0];
      r.last  = last;
      owed_q.insert(owed_q.size(), r);
      for (int i = 1; i < held_count; i++) begin
        held_hash[i-1] = held_hash[i];
        held_mark[i-1] = held_mark[i];
      end
      if (held_count > 0) begin
        held_count--;
        held_hash[held_count] = '0;
        held_mark[held_count] = 1'b0;
      end
    endfunction

    // accepted request: buffer it, scan every full window, flush on end of sequence
    function void take_hash(logic [HASH_W-1:0] h, bit eos);
      int unsigned       w;
      int unsigned       pos;
      logic [HASH_W-1:0] m;
      w = span();
      if (held_count < MAX_WIN) begin
        held_hash[held_count] = h;
        held_mark[held_count] = 1'b0;
        held_count++;
      end
      while (held_count >= w) begin
        m   = held_hash[0];
        pos = 0;
        for (int j = 1; j < w; j++) begin
          if (held_hash[j] < m) begin
            m   = held_hash[j];
            pos = j;
          end
        end
        if (m != NO_KMER) held_mark[pos] = 1'b1;
        retire_oldest(eos && held_count == 1);
      end
      if (eos) begin
        while (held_count > 0) retire_oldest(held_count == 1);
        for (int i = 0; i < MAX_WIN; i++) held_mark[i] = 1'b0;
      end
    endfunction

    function void note_error();
      errors++;
    endfunction

    // compare one result against the oldest owed position
    function void check_position(logic [HASH_W-1:0] v, logic mark, logic last);
      final_pos_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed: value %h mark %b last %b",
                 $time, v, mark, last);
        note_error();
        return;
      end
      e = owed_q.pop_front();
      if (v !== e.value) begin
        $display("%0t: position_value expected %h actual %h", $time, e.value, v);
        note_error();
      end
      if (mark !== e.mark) begin
        $display("%0t: is_minimizer expected %b actual %b (value %h)",
                 $time, e.mark, mark, e.value);
        note_error();
      end
      if (last !== e.last) begin
        $display("%0t: last_of_sequence expected %b actual %b (value %h)",
                 $time, e.last, last, e.value);
        note_error();
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [HASH_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [HASH_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  minimizer_scoreboard sb;
  bit                  no_idle = 1'b0;
  int unsigned         rx_wait = 0;
  int unsigned         rx_pause;

  window_minimizer_marker #(
    .MAX_WINDOW(MAX_WIN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [63:0] hash_value
    .s_axis_tlast (s_axis_tlast),   // end_of_sequence
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [63:0] position_value
    .m_axis_tuser (m_axis_tuser),   // [0] is_minimizer
    .m_axis_tlast (m_axis_tlast),   // last_of_sequence
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // result side: check each accepted result, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sb.check_position(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      rx_pause = no_idle ? 0 : $urandom_range(0, 6);
      if (rx_pause == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait       <= rx_pause - 1;
      end
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // one hash request, after a random gap
  task automatic send_item(input logic [HASH_W-1:0] h, input bit last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.take_hash(h, last);
  endtask

  // stop sending, wait for every owed result, then let the sequencer go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // window size write while idle
  task automatic set_window(input logic [CFG_W-1:0] w);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_window(w);
    cfg_valid <= 1'b0;
  endtask

  // hash content: full range, narrow range for ties, or near the sentinel
  function automatic logic [HASH_W-1:0] next_hash(int unsigned mode);
    if ($urandom_range(0, 9) == 0) return NO_KMER;
    case (mode)
      0:       return {$urandom, $urandom};
      1:       return 64'($urandom_range(0, 7));
      default: return NO_KMER - 64'($urandom_range(0, 3));
    endcase
  endfunction

  // stimulus
  initial begin
    logic [CFG_W-1:0] w;
    int unsigned      eff;
    int unsigned      len;
    int unsigned      mode;
    int unsigned      cut;
    int unsigned      sent_random;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of 8, run shorter than the window: all unmarked
    send_item(64'h0, 1'b0);
    send_item(NO_KMER, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);

    // window of one: every position but the sentinel is marked
    set_window(6'd1);
    send_item(NO_KMER, 1'b0);
    send_item(64'h0, 1'b0);
    send_item(64'h1, 1'b1);

    // window size zero acts as one
    set_window(6'd0);
    send_item(64'h7, 1'b0);
    send_item(64'h7, 1'b1);

    // ties pick the leftmost, all-sentinel windows mark nothing
    set_window(6'd3);
    send_item(64'h5, 1'b0);
    send_item(64'h5, 1'b0);
    send_item(64'h5, 1'b0);
    send_item(64'h9, 1'b0);
    send_item(NO_KMER, 1'b0);
    send_item(NO_KMER, 1'b0);
    send_item(NO_KMER, 1'b0);
    send_item(64'h2, 1'b1);

    // window lowered mid-sequence: one request retires several positions
    set_window(6'd8);
    send_item(64'h9, 1'b0);
    send_item(64'h3, 1'b0);
    send_item(64'h3, 1'b0);
    send_item(64'h8, 1'b0);
    send_item(64'h1, 1'b0);
    send_item(64'h1, 1'b0);
    set_window(6'd2);
    send_item(64'h4, 1'b1);

    // random runs over several window sizes, some with a mid-run resize
    sent_random = 0;
    while (sent_random < 140) begin
      case ($urandom_range(0, 11))
        0:       w = 6'd1;
        1:       w = 6'd2;
        2:       w = 6'd3;
        3:       w = 6'd4;
        4:       w = 6'd5;
        5:       w = 6'd8;
        6:       w = 6'd16;
        7:       w = 6'd31;
        8:       w = 6'd32;
        9:       w = 6'd33;
        10:      w = 6'd63;
        default: w = CFG_W'($urandom_range(1, 32));
      endcase
      set_window(w);
      eff     = (w == 0) ? 1 : ((w > MAX_WIN) ? MAX_WIN : w);
      len     = $urandom_range(1, eff + 8);
      mode    = $urandom_range(0, 2);
      no_idle = ($urandom_range(0, 3) == 0);
      cut     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        if (cut != 0 && i == cut) set_window(CFG_W'($urandom_range(0, eff)));
        send_item(next_hash(mode), i == len - 1);
      end
      sent_random += len;
    end

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** window_minimizer_marker: PASSED **");
    end else begin
      $display("** window_minimizer_marker: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("** window_minimizer_marker: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
src/wmm_pkg.sv
src/wmm_value_ram.sv
src/wmm_min_unit.sv
src/window_minimizer_marker.sv
verif/tb_top.sv
